FILE: design/drt_pkg.sv
// Shared constants and types for the dirty rectangle tracker.
`timescale 1ns / 1ps

package drt_pkg;

	localparam int RECT_SLOTS = 16;
	localparam int COORD_BITS = 16;
	localparam int IDX_BITS   = (RECT_SLOTS > 1) ? $clog2(RECT_SLOTS) : 1;
	localparam int CNT_BITS   = $clog2(RECT_SLOTS + 1);

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef coord_t [3:0] box_t;	// 0 min_x, 1 min_y, 2 max_x, 3 max_y
	typedef logic [IDX_BITS-1:0] idx_t;
	typedef logic [CNT_BITS-1:0] cnt_t;

	typedef enum logic [1:0] {
		KIND_UNION = 2'd0,
		KIND_RECT  = 2'd1,
		KIND_EMPTY = 2'd2
	} kind_t;

	localparam coord_t COORD_TOP = coord_t'({1'b0, {(COORD_BITS-1){1'b1}}});
	localparam coord_t COORD_BOT = ~COORD_TOP;
	localparam idx_t   LAST_IDX  = idx_t'(RECT_SLOTS - 1);
	localparam cnt_t   CNT_FULL  = cnt_t'(RECT_SLOTS);

endpackage

FILE: design/dirty_rectangle_tracker.sv
// Dirty rectangle tracker: running union box and a fixed list of dirty rectangles.
`timescale 1ns / 1ps

// An add item (operation 0) widens the running union and stores its box in the
// next free list slot; once all RECT_SLOTS slots hold a box, further boxes are
// merged into the last slot. It gives one result, the new union, and the input
// is ready again in the cycle that this result is registered. A single signed
// compare unit updates one coordinate per cycle, and the merge needs four more
// steps plus a write back to the list memory; the result waits for a free output
// register. A frame item (operation 1)
// reads the list out in storage order, one stored rectangle at a time
// through the memory's one registered read port, with last set on
// the final one; an empty list gives a single empty marker with zero
// coordinates. The list is then emptied and the union set to the inverted box
// (largest minimum, smallest maximum). in_stall stays high while an item is in
// progress; a finished result waits in the output register and does not block
// the next input transfer.
module dirty_rectangle_tracker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             operation,
	input  drt_pkg::coord_t  box_min_x,
	input  drt_pkg::coord_t  box_min_y,
	input  drt_pkg::coord_t  box_max_x,
	input  drt_pkg::coord_t  box_max_y,
	output logic             out_valid,
	input  logic             out_stall,
	output drt_pkg::kind_t   kind,
	output drt_pkg::coord_t  out_min_x,
	output drt_pkg::coord_t  out_min_y,
	output drt_pkg::coord_t  out_max_x,
	output drt_pkg::coord_t  out_max_y,
	output logic             last
);
	import drt_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UNION,
		ST_MERGE,
		ST_MERGE_WB,
		ST_ADD_EMIT,
		ST_EMPTY_EMIT,
		ST_FRM_RD,
		ST_FRM_EMIT
	} state_t;

	// Widen one coordinate: minimum edges take the smaller, maximum edges the larger.
	function automatic coord_t widen_one(input logic is_max, input coord_t cur,
			input coord_t nxt);
		coord_t r;
		r = cur;
		if (is_max) begin
			if (nxt > cur) r = nxt;
		end else begin
			if (nxt < cur) r = nxt;
		end
		return r;
	endfunction

	state_t      state_q;
	cnt_t        count_q;
	idx_t        idx_q;
	logic [1:0]  axis_q;
	logic        merge_q;
	box_t        union_q;
	box_t        box_q;
	box_t        acc_q;
	box_t        rd_q;
	box_t        mem [RECT_SLOTS];

	logic        out_valid_q;
	kind_t       kind_q;
	box_t        out_box_q;
	logic        last_q;

	logic        accept;
	logic        full;
	logic        out_free;
	logic        emit_now;
	logic        frm_last;
	box_t        in_box;
	coord_t      alu_a;
	coord_t      alu_res;
	logic        mem_we;
	idx_t        mem_waddr;
	box_t        mem_wdata;
	logic        mem_re;
	idx_t        mem_raddr;

	assign in_box   = {box_max_y, box_max_x, box_min_y, box_min_x};
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && (state_q == ST_IDLE);
	assign full     = (count_q == CNT_FULL);
	assign out_free = !out_valid_q || !out_stall;
	assign emit_now = out_free && ((state_q == ST_ADD_EMIT) || (state_q == ST_EMPTY_EMIT) ||
		(state_q == ST_FRM_EMIT));
	assign frm_last = ((cnt_t'(idx_q) + cnt_t'(1)) == count_q);

	// Shared compare unit, one axis per cycle.
	assign alu_a   = (state_q == ST_MERGE) ? rd_q[axis_q] : union_q[axis_q];
	assign alu_res = widen_one(axis_q[1], alu_a, box_q[axis_q]);

	always_comb begin
		mem_we    = (accept && !operation && !full) || (state_q == ST_MERGE_WB);
		mem_waddr = (state_q == ST_MERGE_WB) ? LAST_IDX : count_q[IDX_BITS-1:0];
		mem_wdata = (state_q == ST_MERGE_WB) ? acc_q : in_box;
		mem_re    = accept || (state_q == ST_FRM_RD);
		if (state_q == ST_FRM_RD) begin
			mem_raddr = idx_q;
		end else if (operation) begin
			mem_raddr = '0;
		end else begin
			mem_raddr = LAST_IDX;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			box_q <= in_box;
		end
		if (state_q == ST_MERGE) begin
			acc_q[axis_q] <= alu_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			axis_q      <= '0;
			merge_q     <= 1'b0;
			union_q     <= {COORD_BOT, COORD_BOT, COORD_TOP, COORD_TOP};
			out_valid_q <= 1'b0;
			kind_q      <= KIND_UNION;
			out_box_q   <= '0;
			last_q      <= 1'b0;
		end else begin
			if (emit_now) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					axis_q <= '0;
					idx_q  <= '0;
					if (accept) begin
						if (!operation) begin
							merge_q <= full;
							if (!full) begin
								count_q <= count_q + cnt_t'(1);
							end
							state_q <= ST_UNION;
						end else if (count_q == '0) begin
							state_q <= ST_EMPTY_EMIT;
						end else begin
							state_q <= ST_FRM_EMIT;
						end
					end
				end
				ST_UNION: begin
					union_q[axis_q] <= alu_res;
					axis_q          <= axis_q + 2'd1;
					if (axis_q == 2'd3) begin
						state_q <= merge_q ? ST_MERGE : ST_ADD_EMIT;
					end
				end
				ST_MERGE: begin
					axis_q <= axis_q + 2'd1;
					if (axis_q == 2'd3) begin
						state_q <= ST_MERGE_WB;
					end
				end
				ST_MERGE_WB: begin
					state_q <= ST_ADD_EMIT;
				end
				ST_ADD_EMIT: begin
					if (out_free) begin
						kind_q      <= KIND_UNION;
						out_box_q   <= union_q;
						last_q      <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				ST_EMPTY_EMIT: begin
					if (out_free) begin
						kind_q      <= KIND_EMPTY;
						out_box_q   <= '0;
						last_q      <= 1'b1;
						count_q     <= '0;
						union_q     <= {COORD_BOT, COORD_BOT, COORD_TOP, COORD_TOP};
						state_q     <= ST_IDLE;
					end
				end
				ST_FRM_RD: begin
					state_q <= ST_FRM_EMIT;
				end
				ST_FRM_EMIT: begin
					if (out_free) begin
						kind_q      <= KIND_RECT;
						out_box_q   <= rd_q;
						last_q      <= frm_last;
						if (frm_last) begin
							// drop the list and invert the union
							count_q <= '0;
							union_q <= {COORD_BOT, COORD_BOT, COORD_TOP, COORD_TOP};
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_q + idx_t'(1);
							state_q <= ST_FRM_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign out_min_x = out_box_q[0];
	assign out_min_y = out_box_q[1];
	assign out_max_x = out_box_q[2];
	assign out_max_y = out_box_q[3];
	assign last      = last_q;

endmodule
